>>> src/mcvq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcvq_pkg
// Types and codes shared by the minimum-cost vertex queue and its cells.
// ----------------------------------------------------------------------------
package mcvq_pkg;

    localparam int VID_W  = 16;
    localparam int COST_W = 32;
    localparam int OCC_W  = 7;
    localparam int REQ_W  = 3;
    localparam int ST_W   = 2;

    localparam logic [REQ_W-1:0] REQ_INSERT = 3'd0;
    localparam logic [REQ_W-1:0] REQ_POP    = 3'd1;
    localparam logic [REQ_W-1:0] REQ_PEEK   = 3'd2;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 3'd3;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd4;

    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY     = 2'd1;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [ST_W-1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [VID_W-1:0]  vertex_id;
        logic [COST_W-1:0] key_cost;
    } t_req;

    typedef struct packed {
        logic [VID_W-1:0]  out_vertex;
        logic [COST_W-1:0] out_cost;
        logic [ST_W-1:0]   status;
        logic [OCC_W-1:0]  occupancy;
    } t_rsp;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    // per-cell update command
    typedef struct packed {
        logic load;
        logic shift;
        logic clear;
    } t_cell_cmd;

    // search token travelling along the chain
    typedef struct packed {
        logic              live;
        logic              match;
        logic              found;
        logic [COST_W-1:0] best_cost;
    } t_tok;

endpackage

>>> src/min_cost_vertex_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_cost_vertex_queue
// Bounded minimum-cost queue of (vertex, cost) entries with removal by vertex.
// ----------------------------------------------------------------------------
// One request is taken at a time and each returns one response beat. Insert,
// clear, unused codes and pop or peek on an empty queue go straight to the
// done state, which moves the response into the output register. Pop and peek
// on a queue that holds entries, and remove, first pass through the scan state:
// a search token walks the chain of slot cells one cell per cycle, picking the
// oldest least-cost entry or the newest entry of the named vertex, and the
// chosen slot is then closed up by shifting the slots above it down one place.
// A response still waiting in the output register holds the next one back until
// it is taken. The next request is accepted as soon as the response is in the
// output register, even while it waits there.
// ----------------------------------------------------------------------------
module min_cost_vertex_queue
    import mcvq_pkg::*;
#(
    parameter int CAPACITY    = 64,
    parameter int VERTEX_BITS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_req i_req,
    output logic o_valid,
    input  logic i_ready,
    output t_rsp o_rsp
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    t_state                 r_state, n_state;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic [REQ_W-1:0]       r_op, n_op;
    logic [VERTEX_BITS-1:0] r_key, n_key;
    t_rsp                   r_pend, n_pend;
    logic                   r_out_valid, n_out_valid;
    t_rsp                   r_rsp, n_rsp;

    logic                   w_accept;
    logic [VERTEX_BITS-1:0] w_in_vid;
    logic                   w_wr_en;
    logic                   w_drop_en;
    logic                   w_clr_en;

    t_cell_cmd              w_cmd        [CAPACITY];
    logic                   w_valid      [CAPACITY+1];
    logic [VERTEX_BITS-1:0] w_vertex     [CAPACITY+1];
    logic [COST_W-1:0]      w_cost       [CAPACITY+1];
    t_tok                   w_tok        [CAPACITY+1];
    logic [VERTEX_BITS-1:0] w_tok_key    [CAPACITY+1];
    logic [VERTEX_BITS-1:0] w_tok_vertex [CAPACITY+1];
    logic [IDX_W-1:0]       w_tok_idx    [CAPACITY+1];

    assign o_ready  = (r_state == S_IDLE);
    assign w_accept = i_valid && o_ready;
    assign w_in_vid = VERTEX_BITS'(i_req.vertex_id);

    // empty neighbour above the top slot
    assign w_valid[CAPACITY]  = 1'b0;
    assign w_vertex[CAPACITY] = '0;
    assign w_cost[CAPACITY]   = '0;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_op        = r_op;
        n_key       = r_key;
        n_pend      = r_pend;
        n_rsp       = r_rsp;
        n_out_valid = r_out_valid && !i_ready;
        w_wr_en     = 1'b0;
        w_drop_en   = 1'b0;
        w_clr_en    = 1'b0;

        w_tok[0]        = '0;
        w_tok_key[0]    = w_in_vid;
        w_tok_vertex[0] = '0;
        w_tok_idx[0]    = '0;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_op   = i_req.req_type;
                    n_key  = w_in_vid;
                    n_pend = '0;
                    unique case (i_req.req_type)
                        REQ_INSERT: begin
                            n_pend.out_vertex = VID_W'(w_in_vid);
                            n_pend.out_cost   = i_req.key_cost;
                            if (r_cnt == CNT_W'(CAPACITY)) begin
                                n_pend.status = ST_FULL;
                            end else begin
                                w_wr_en = 1'b1;
                                n_cnt   = r_cnt + 1'b1;
                            end
                            n_state = S_DONE;
                        end
                        REQ_POP, REQ_PEEK: begin
                            if (r_cnt == '0) begin
                                n_pend.status = ST_EMPTY;
                                n_state       = S_DONE;
                            end else begin
                                w_tok[0].live = 1'b1;
                                n_state       = S_SCAN;
                            end
                        end
                        REQ_REMOVE: begin
                            w_tok[0].live  = 1'b1;
                            w_tok[0].match = 1'b1;
                            n_state        = S_SCAN;
                        end
                        REQ_CLEAR: begin
                            w_clr_en = 1'b1;
                            n_cnt    = '0;
                            n_state  = S_DONE;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (w_tok[CAPACITY].live) begin
                    n_pend = '0;
                    if (w_tok[CAPACITY].found) begin
                        n_pend.out_vertex = VID_W'(w_tok_vertex[CAPACITY]);
                        n_pend.out_cost   = w_tok[CAPACITY].best_cost;
                        if (r_op != REQ_PEEK) begin
                            w_drop_en = 1'b1;
                            n_cnt     = r_cnt - 1'b1;
                        end
                    end else begin
                        n_pend.out_vertex = VID_W'(r_key);
                        n_pend.status     = ST_NOT_FOUND;
                    end
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_rsp           = r_pend;
                    n_rsp.occupancy = OCC_W'(r_cnt);
                    n_out_valid     = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_key  <= n_key;
        r_pend <= n_pend;
        r_rsp  <= n_rsp;
    end

    assign o_valid = r_out_valid;
    assign o_rsp   = r_rsp;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        always_comb begin
            w_cmd[g].load  = w_wr_en && (r_cnt == CNT_W'(g));
            w_cmd[g].shift = w_drop_en && (IDX_W'(g) >= w_tok_idx[CAPACITY]);
            w_cmd[g].clear = w_clr_en;
        end

        mcvq_cell #(
            .VERTEX_BITS (VERTEX_BITS),
            .IDX_W       (IDX_W),
            .INDEX       (g)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_cmd         (w_cmd[g]),
            .i_new_vertex  (w_in_vid),
            .i_new_cost    (i_req.key_cost),
            .i_next_valid  (w_valid[g+1]),
            .i_next_vertex (w_vertex[g+1]),
            .i_next_cost   (w_cost[g+1]),
            .o_valid       (w_valid[g]),
            .o_vertex      (w_vertex[g]),
            .o_cost        (w_cost[g]),
            .i_tok         (w_tok[g]),
            .i_tok_key     (w_tok_key[g]),
            .i_tok_vertex  (w_tok_vertex[g]),
            .i_tok_idx     (w_tok_idx[g]),
            .o_tok         (w_tok[g+1]),
            .o_tok_key     (w_tok_key[g+1]),
            .o_tok_vertex  (w_tok_vertex[g+1]),
            .o_tok_idx     (w_tok_idx[g+1])
        );
    end

endmodule

>>> src/mcvq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcvq_cell
// One queue slot: holds an entry, shifts in its upper neighbour on a
// removal and passes the search token on to the next slot each cycle.
// ----------------------------------------------------------------------------
module mcvq_cell
    import mcvq_pkg::*;
#(
    parameter int VERTEX_BITS = 16,
    parameter int IDX_W       = 6,
    parameter int INDEX       = 0
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cell_cmd              i_cmd,
    input  logic [VERTEX_BITS-1:0] i_new_vertex,
    input  logic [COST_W-1:0]      i_new_cost,
    input  logic                   i_next_valid,
    input  logic [VERTEX_BITS-1:0] i_next_vertex,
    input  logic [COST_W-1:0]      i_next_cost,
    output logic                   o_valid,
    output logic [VERTEX_BITS-1:0] o_vertex,
    output logic [COST_W-1:0]      o_cost,
    input  t_tok                   i_tok,
    input  logic [VERTEX_BITS-1:0] i_tok_key,
    input  logic [VERTEX_BITS-1:0] i_tok_vertex,
    input  logic [IDX_W-1:0]       i_tok_idx,
    output t_tok                   o_tok,
    output logic [VERTEX_BITS-1:0] o_tok_key,
    output logic [VERTEX_BITS-1:0] o_tok_vertex,
    output logic [IDX_W-1:0]       o_tok_idx
);

    logic                   r_valid;
    logic [VERTEX_BITS-1:0] r_vertex;
    logic [COST_W-1:0]      r_cost;

    logic                   r_tok_live;
    t_tok                   r_tok;
    logic [VERTEX_BITS-1:0] r_tok_key;
    logic [VERTEX_BITS-1:0] r_tok_vertex;
    logic [IDX_W-1:0]       r_tok_idx;

    t_tok                   n_tok;
    logic [VERTEX_BITS-1:0] n_tok_vertex;
    logic [IDX_W-1:0]       n_tok_idx;
    logic                   w_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.clear) begin
            r_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_valid <= 1'b1;
        end else if (i_cmd.shift) begin
            r_valid <= i_next_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_vertex <= i_new_vertex;
            r_cost   <= i_new_cost;
        end else if (i_cmd.shift) begin
            r_vertex <= i_next_vertex;
            r_cost   <= i_next_cost;
        end
    end

    always_comb begin
        w_hit = i_tok.live && r_valid &&
                (i_tok.match ? (r_vertex == i_tok_key)
                             : (!i_tok.found || (r_cost < i_tok.best_cost)));
        n_tok        = i_tok;
        n_tok_vertex = i_tok_vertex;
        n_tok_idx    = i_tok_idx;
        if (w_hit) begin
            n_tok.found     = 1'b1;
            n_tok.best_cost = r_cost;
            n_tok_vertex    = r_vertex;
            n_tok_idx       = IDX_W'(INDEX);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok_live <= 1'b0;
        end else begin
            r_tok_live <= i_tok.live;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tok        <= n_tok;
        r_tok_key    <= i_tok_key;
        r_tok_vertex <= n_tok_vertex;
        r_tok_idx    <= n_tok_idx;
    end

    always_comb begin
        o_tok      = r_tok;
        o_tok.live = r_tok_live;
    end

    assign o_valid      = r_valid;
    assign o_vertex     = r_vertex;
    assign o_cost       = r_cost;
    assign o_tok_key    = r_tok_key;
    assign o_tok_vertex = r_tok_vertex;
    assign o_tok_idx    = r_tok_idx;

endmodule

>>> tb/vertex_queue_predictor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_queue_predictor
// Watches both channels of the minimum-cost vertex queue, keeps its own copy
// of the queued entries in insertion order, works out the response of every
// accepted request and compares each response beat with the oldest one due.
// ----------------------------------------------------------------------------
module vertex_queue_predictor
    import mcvq_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    input  logic i_req_ready,
    input  t_req i_req,
    input  logic i_rsp_valid,
    input  logic i_rsp_ready,
    input  t_rsp i_rsp,
    output int   o_fail_count,
    output int   o_due_count
);

    // queued entries, oldest first
    logic [COST_W-1:0] held_cost[$];
    logic [VID_W-1:0]  held_vertex[$];
    t_rsp              due_rsps[$];
    int                fail_count = 0;

    function automatic t_rsp apply_request(input t_req r);
        t_rsp rsp;
        int   pick;
        rsp  = '0;
        pick = -1;
        case (r.req_type)
            REQ_INSERT: begin
                rsp.out_vertex = r.vertex_id;
                rsp.out_cost   = r.key_cost;
                if (held_cost.size() >= CAPACITY) begin
                    rsp.status = ST_FULL;
                end else begin
                    held_cost.push_back(r.key_cost);
                    held_vertex.push_back(r.vertex_id);
                end
            end
            REQ_POP, REQ_PEEK: begin
                if (held_cost.size() == 0) begin
                    rsp.status = ST_EMPTY;
                end else begin
                    // oldest entry wins a tie
                    pick = 0;
                    for (int i = 1; i < held_cost.size(); i++) begin
                        if (held_cost[i] < held_cost[pick]) pick = i;
                    end
                    rsp.out_vertex = held_vertex[pick];
                    rsp.out_cost   = held_cost[pick];
                    if (r.req_type == REQ_POP) begin
                        held_cost.delete(pick);
                        held_vertex.delete(pick);
                    end
                end
            end
            REQ_REMOVE: begin
                // newest entry of the vertex
                for (int i = 0; i < held_vertex.size(); i++) begin
                    if (held_vertex[i] == r.vertex_id) pick = i;
                end
                if (pick >= 0) begin
                    rsp.out_vertex = held_vertex[pick];
                    rsp.out_cost   = held_cost[pick];
                    held_cost.delete(pick);
                    held_vertex.delete(pick);
                end else begin
                    rsp.out_vertex = r.vertex_id;
                    rsp.status     = ST_NOT_FOUND;
                end
            end
            REQ_CLEAR: begin
                held_cost.delete();
                held_vertex.delete();
            end
            default: begin
            end
        endcase
        rsp.occupancy = OCC_W'(held_cost.size());
        return rsp;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            held_cost.delete();
            held_vertex.delete();
            due_rsps.delete();
        end else begin
            if (i_req_valid && i_req_ready) due_rsps.push_back(apply_request(i_req));
            if (i_rsp_valid && i_rsp_ready) begin
                if (due_rsps.size() == 0) begin
                    $error("response beat with none due, vertex 0x%0h status %0d",
                           i_rsp.out_vertex, i_rsp.status);
                    fail_count++;
                end else begin
                    want = due_rsps.pop_front();
                    check_field("out_vertex", 32'(want.out_vertex), 32'(i_rsp.out_vertex));
                    check_field("out_cost", want.out_cost, i_rsp.out_cost);
                    check_field("status", 32'(want.status), 32'(i_rsp.status));
                    check_field("occupancy", 32'(want.occupancy), 32'(i_rsp.occupancy));
                end
            end
        end
        o_fail_count <= fail_count;
        o_due_count  <= due_rsps.size();
    end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives requests into the minimum-cost vertex queue: a short directed run
// over empty, tie, duplicate-vertex, clear and unused-code cases, then random
// segments that fill, drain or churn the queue. The sender works in bursts,
// the receiver stalls on changing patterns with one long hold-off, and the
// predictor beside the block checks every response beat.
// ----------------------------------------------------------------------------
module testbench;
    import mcvq_pkg::*;

    localparam int CAPACITY       = 64;
    localparam int VERTEX_BITS    = 16;
    localparam int RESET_CYCLES   = 10;
    localparam int RANDOM_ITEMS   = 1925;
    localparam int HOLD_START     = 1500;
    localparam int HOLD_CYCLES    = 600;
    localparam int DRAIN_CYCLES   = 2 * CAPACITY + 8;
    localparam int WATCHDOG_LIMIT = 5000;

    typedef enum int {
        MIX_FILL,
        MIX_DRAIN,
        MIX_CHURN,
        MIX_TIES
    } t_mix;

    typedef enum int {
        SINK_OPEN,
        SINK_COIN,
        SINK_SPARSE,
        SINK_PERIODIC
    } t_sink_style;

    logic i_clk;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    t_req i_req   = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    t_rsp o_rsp;
    int   fail_count;
    int   due_count;
    int   burst_left = 0;

    min_cost_vertex_queue #(
        .CAPACITY    (CAPACITY),
        .VERTEX_BITS (VERTEX_BITS)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_req   (i_req),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_rsp   (o_rsp)
    );

    vertex_queue_predictor #(
        .CAPACITY (CAPACITY)
    ) u_predict (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_valid),
        .i_req_ready  (o_ready),
        .i_req        (i_req),
        .i_rsp_valid  (o_valid),
        .i_rsp_ready  (i_ready),
        .i_rsp        (o_rsp),
        .o_fail_count (fail_count),
        .o_due_count  (due_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic t_req mk_req(input logic [REQ_W-1:0] kind,
                                    input logic [VID_W-1:0] vid,
                                    input logic [COST_W-1:0] cost);
        t_req r;
        r.req_type  = kind;
        r.vertex_id = vid;
        r.key_cost  = cost;
        return r;
    endfunction

    function automatic t_req make_request(input t_mix mix);
        t_req r;
        int   roll;
        int   ins_pct;
        int   pop_pct;
        int   peek_pct;
        int   rem_pct;
        case (mix)
            MIX_FILL: begin
                ins_pct = 85; pop_pct = 6;  peek_pct = 3;  rem_pct = 5;
            end
            MIX_DRAIN: begin
                ins_pct = 15; pop_pct = 45; peek_pct = 10; rem_pct = 28;
            end
            default: begin
                ins_pct = 45; pop_pct = 25; peek_pct = 10; rem_pct = 17;
            end
        endcase

        if (mix == MIX_TIES) begin
            r.vertex_id = VID_W'($urandom_range(0, 3));
        end else if ($urandom_range(0, 9) < 7) begin
            r.vertex_id = VID_W'($urandom_range(0, 15));
        end else begin
            r.vertex_id = VID_W'($urandom);
        end

        roll = $urandom_range(0, 9);
        if (mix == MIX_TIES || roll < 4) begin
            r.key_cost = COST_W'($urandom_range(0, 7));
        end else if (roll < 8) begin
            r.key_cost = $urandom;
        end else if (roll == 8) begin
            r.key_cost = $urandom_range(0, 1) ? '1 : '0;
        end else begin
            // whole units only
            r.key_cost = $urandom & 32'hFFFF_0000;
        end

        roll = $urandom_range(0, 99);
        if (roll < ins_pct) begin
            r.req_type = REQ_INSERT;
        end else if (roll < ins_pct + pop_pct) begin
            r.req_type = REQ_POP;
        end else if (roll < ins_pct + pop_pct + peek_pct) begin
            r.req_type = REQ_PEEK;
        end else if (roll < ins_pct + pop_pct + peek_pct + rem_pct) begin
            r.req_type = REQ_REMOVE;
        end else if ($urandom_range(0, 3) == 0) begin
            r.req_type = REQ_CLEAR;
        end else begin
            // unused codes above clear
            r.req_type = REQ_CLEAR + REQ_W'($urandom_range(1, 3));
        end
        return r;
    endfunction

    task automatic send_beat(input t_req r);
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_req   <= r;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic offer(input t_req r);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 3) != 0) begin
                gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 90)
                                                  : $urandom_range(1, 6);
                @(negedge i_clk);
                i_valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        send_beat(r);
        burst_left--;
    endtask

    initial begin : stimulus
        t_req directed[$];
        t_req r;
        t_mix mix;
        int   seg_len;
        int   counted;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        directed.push_back(mk_req(REQ_POP, 16'h0000, 32'h0000_0000));
        directed.push_back(mk_req(REQ_PEEK, 16'h0000, 32'h0000_0000));
        directed.push_back(mk_req(REQ_REMOVE, 16'hFFFF, 32'hFFFF_FFFF));
        directed.push_back(mk_req(REQ_INSERT, 16'hFFFF, 32'hFFFF_FFFF));
        directed.push_back(mk_req(REQ_INSERT, 16'h0000, 32'h0000_0000));
        directed.push_back(mk_req(REQ_INSERT, 16'h0005, 32'h0001_0000));
        directed.push_back(mk_req(REQ_INSERT, 16'h0007, 32'h0001_0000));
        directed.push_back(mk_req(REQ_INSERT, 16'h0005, 32'h0002_0000));
        directed.push_back(mk_req(REQ_REMOVE, 16'h0005, 32'h0000_0000));
        directed.push_back(mk_req(REQ_PEEK, 16'h0000, 32'h0000_0000));
        directed.push_back(mk_req(REQ_POP, 16'h0000, 32'h0000_0000));
        directed.push_back(mk_req(REQ_POP, 16'h0000, 32'h0000_0000));
        directed.push_back(mk_req(REQ_REMOVE, 16'h0009, 32'h0000_0000));
        directed.push_back(mk_req(REQ_CLEAR + 3'd1, 16'hAAAA, 32'h5555_5555));
        directed.push_back(mk_req(REQ_CLEAR + 3'd2, 16'h5555, 32'hAAAA_AAAA));
        directed.push_back(mk_req(REQ_CLEAR + 3'd3, 16'hFFFF, 32'hFFFF_FFFF));
        directed.push_back(mk_req(REQ_PEEK, 16'h0000, 32'h0000_0000));
        directed.push_back(mk_req(REQ_CLEAR, 16'h0000, 32'h0000_0000));
        directed.push_back(mk_req(REQ_PEEK, 16'h0000, 32'h0000_0000));
        directed.push_back(mk_req(REQ_INSERT, 16'h8000, 32'h8000_0000));
        directed.push_back(mk_req(REQ_INSERT, 16'h1234, 32'hFFFF_FFFF));
        directed.push_back(mk_req(REQ_POP, 16'h0000, 32'h0000_0000));
        directed.push_back(mk_req(REQ_REMOVE, 16'h1234, 32'h0000_0000));
        directed.push_back(mk_req(REQ_POP, 16'h0000, 32'h0000_0000));

        foreach (directed[k]) offer(directed[k]);

        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            mix     = t_mix'($urandom_range(0, 3));
            seg_len = (mix == MIX_FILL) ? $urandom_range(60, 160) : $urandom_range(20, 120);
            repeat (seg_len) begin
                r = make_request(mix);
                offer(r);
                if (r.req_type <= REQ_CLEAR) counted++;
            end
        end
        @(negedge i_clk);
        i_valid <= 1'b0;

        while (due_count != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (fail_count == 0 && due_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin : rsp_sink
        t_sink_style style;
        int          stretch;
        int          elapsed;
        bit          held_off;

        held_off = 1'b0;
        elapsed  = 0;
        @(negedge i_clk);
        while (!i_rst_n) @(negedge i_clk);
        forever begin
            // one long hold-off so the queue backs up into its input
            if (!held_off && elapsed >= HOLD_START) begin
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                held_off = 1'b1;
            end
            style   = t_sink_style'($urandom_range(0, 3));
            stretch = $urandom_range(30, 250);
            repeat (stretch) begin
                case (style)
                    SINK_OPEN:   i_ready <= 1'b1;
                    SINK_COIN:   i_ready <= 1'($urandom_range(0, 1));
                    SINK_SPARSE: i_ready <= ($urandom_range(0, 3) == 0);
                    default:     i_ready <= ((elapsed % 7) < 2);
                endcase
                elapsed++;
                @(negedge i_clk);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("Verification failed");
        $finish;
    end

endmodule
